FILE: rtl/sfpp_pkg.sv
// shared constants for the sync framed packet parser
`default_nettype none

package sfpp_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 6;
    localparam int ST_W   = 2;
    localparam int IDX_W  = 2;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hBB;

    // result status codes
    localparam logic [ST_W-1:0] ST_NONE = 2'd0;
    localparam logic [ST_W-1:0] ST_GOOD = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD  = 2'd2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_COMMAND_CODE   = 2'd0;
    localparam logic [IDX_W-1:0] REG_PAYLOAD_LENGTH = 2'd1;

endpackage

`default_nettype wire

FILE: rtl/sfpp_ram.sv
// generic single write port ram with registered read
`default_nettype none

module sfpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sync_framed_packet_parser.sv
// top level of the sync framed packet parser
// a status result is registered and valid the cycle after its byte is accepted
// one byte is taken per cycle while hunting and collecting, when the output is not stalled
// a good check byte gives n payload items, each read from the payload ram, then sent,
// paced by the single read port of the ram and by output stalls; no byte is taken meanwhile
// reset is synchronous and active low; it resets control state and config registers,
// the payload ram is not cleared since only entries of the current frame are read
`default_nettype none

module sync_framed_packet_parser
    import sfpp_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // byte input
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [BYTE_W-1:0] i_rx_byte,
    // result output
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic      [ST_W-1:0]   o_status,
    output logic      [BYTE_W-1:0] o_payload_byte,
    output logic                   o_last,
    // configuration write port
    input  wire logic              i_cfg_we,
    input  wire logic [IDX_W-1:0]  i_cfg_index,
    input  wire logic [BYTE_W-1:0] i_cfg_data
);

    // ram address width and a count wide enough to hold the depth itself
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CW = $clog2(MAX_PAYLOAD + 1);
    localparam int EW = LEN_W + 1;
    localparam logic [EW-1:0] MAX_EXT = EW'(MAX_PAYLOAD);

    // frame phase while parsing
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SYNC2,
        PH_CMD,
        PH_DATA,
        PH_CHECK
    } t_phase;

    // control: parse bytes, or stream the stored payload out
    typedef enum logic [1:0] {
        S_PARSE,
        S_READ,
        S_SEND
    } t_ctl;

    t_ctl              r_ctl,      n_ctl;
    t_phase            r_phase,    n_phase;
    logic [CW-1:0]     r_count,    n_count;
    logic [BYTE_W-1:0] r_check,    n_check;
    logic [CW-1:0]     r_rd_idx,   n_rd_idx;
    logic              r_out_valid, n_out_valid;
    logic [ST_W-1:0]   r_status,   n_status;
    logic [BYTE_W-1:0] r_pbyte,    n_pbyte;
    logic              r_last,     n_last;

    logic [BYTE_W-1:0] r_cmd;
    logic [LEN_W-1:0]  r_len;

    logic [EW-1:0]     w_len_ext;
    logic [CW-1:0]     w_eff_len;
    logic              w_out_free;
    logic              w_in_acc;
    logic              w_ram_we;
    logic              w_ram_re;
    logic [BYTE_W-1:0] w_ram_rdata;

    // length as used: zero counts as one, clamp at the store depth
    assign w_len_ext = {1'b0, r_len};
    always_comb begin
        if (r_len == '0) begin
            w_eff_len = CW'(1);
        end else if (w_len_ext > MAX_EXT) begin
            w_eff_len = CW'(MAX_PAYLOAD);
        end else begin
            w_eff_len = CW'(w_len_ext);
        end
    end

    // output slot can be reloaded when empty or being taken this cycle
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_ctl == S_PARSE) && w_out_free);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // payload writes only happen while parsing, reads only while streaming,
    // so the two ports never touch the same entry in the same cycle
    assign w_ram_we = w_in_acc && (r_phase == PH_DATA) && (r_count < CW'(MAX_PAYLOAD));
    assign w_ram_re = (r_ctl == S_READ);

    sfpp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_re    (w_ram_re),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (w_ram_rdata)
    );

    always_comb begin
        logic [CW-1:0] cnt_inc;

        cnt_inc     = r_count;
        n_ctl       = r_ctl;
        n_phase     = r_phase;
        n_count     = r_count;
        n_check     = r_check;
        n_rd_idx    = r_rd_idx;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_pbyte     = r_pbyte;
        n_last      = r_last;

        // slot drained by the consumer
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_ctl)
            S_PARSE: begin
                if (w_in_acc) begin
                    // default result for an ordinary byte
                    n_out_valid = 1'b1;
                    n_status    = ST_NONE;
                    n_pbyte     = '0;
                    n_last      = 1'b1;
                    unique case (r_phase)
                        PH_HUNT: begin
                            if (i_rx_byte == SYNC_FIRST) begin
                                n_phase = PH_SYNC2;
                            end
                        end
                        PH_SYNC2: begin
                            // a bad second sync byte is not retried as a first one
                            n_phase = (i_rx_byte == SYNC_SECOND) ? PH_CMD : PH_HUNT;
                        end
                        PH_CMD: begin
                            n_count = '0;
                            if (i_rx_byte == r_cmd) begin
                                n_check = BYTE_W'(w_eff_len) ^ r_cmd;
                                n_phase = PH_DATA;
                            end else begin
                                n_phase = PH_HUNT;
                            end
                        end
                        PH_DATA: begin
                            if (r_count < CW'(MAX_PAYLOAD)) begin
                                cnt_inc = r_count + CW'(1);
                            end
                            n_count = cnt_inc;
                            n_check = r_check ^ i_rx_byte;
                            if (cnt_inc >= w_eff_len) begin
                                n_phase = PH_CHECK;
                            end
                        end
                        PH_CHECK: begin
                            n_phase = PH_HUNT;
                            if ((i_rx_byte != r_check) || (r_count == '0)) begin
                                n_status = ST_BAD;
                            end else begin
                                // good frame: no status, stream the payload
                                n_out_valid = 1'b0;
                                n_rd_idx    = '0;
                                n_ctl       = S_READ;
                            end
                        end
                        default: begin
                            n_phase = PH_HUNT;
                        end
                    endcase
                end
            end
            S_READ: begin
                // ram read issued this cycle, data valid next cycle
                n_ctl = S_SEND;
            end
            S_SEND: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_GOOD;
                    n_pbyte     = w_ram_rdata;
                    n_last      = (r_rd_idx + CW'(1)) == r_count;
                    if (n_last) begin
                        n_ctl = S_PARSE;
                    end else begin
                        n_rd_idx = r_rd_idx + CW'(1);
                        n_ctl    = S_READ;
                    end
                end
            end
            default: begin
                n_ctl = S_PARSE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl       <= S_PARSE;
            r_phase     <= PH_HUNT;
            r_count     <= '0;
            r_check     <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
            r_cmd       <= '0;
            r_len       <= LEN_W'(1);
        end else begin
            r_ctl       <= n_ctl;
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_check     <= n_check;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                // unknown indexes are ignored
                if (i_cfg_index == REG_COMMAND_CODE) begin
                    r_cmd <= i_cfg_data;
                end else if (i_cfg_index == REG_PAYLOAD_LENGTH) begin
                    r_len <= i_cfg_data[LEN_W-1:0];
                end
            end
        end
    end

    // payload of the output slot, no reset needed
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_pbyte  <= n_pbyte;
        r_last   <= n_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_payload_byte = r_pbyte;
    assign o_last         = r_last;

endmodule

`default_nettype wire

FILE: rtl/sfpp_checker.sv
// port level assertions for the sync framed packet parser, with bind
`default_nettype none

module sfpp_checker
    import sfpp_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_in_stall,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire logic [ST_W-1:0]   o_status,
    input wire logic [BYTE_W-1:0] o_payload_byte,
    input wire logic              o_last
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_status)
            && $stable(o_payload_byte) && $stable(o_last)))
        else $error("stalled result item changed");

    // status items carry a zero byte and close their byte
    a_status_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_GOOD)) |-> ((o_payload_byte == '0) && o_last))
        else $error("status item with payload or without last");

    // no byte is taken while a good frame is still streaming out
    a_stream_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_GOOD) && !o_last) |-> o_in_stall)
        else $error("input taken during payload stream");

    // reset empties the output slot
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind sync_framed_packet_parser sfpp_checker u_sfpp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_payload_byte (o_payload_byte),
    .o_last         (o_last)
);

`default_nettype wire
